FILE: hdl/pcgr_pkg.sv
// Shared types and constants for the PCG32 bounded random generator.
`timescale 1ns / 1ps
package pcgr_pkg;
  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC = 64'd1442695040888963407;

  typedef enum logic [1:0] {
    ACT_RAW    = 2'd0,
    ACT_BOUND  = 2'd1,
    ACT_RESEED = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // classified command passed from front to back
  typedef struct packed {
    action_t     op;
    logic        zero;
    logic [30:0] bound;
  } cmd_t;

  // Draw permutation (xorshift high, random rotate) of an old state.
  function automatic logic [31:0] permute(input logic [63:0] old);
    logic [63:0] x;
    logic [31:0] mixed;
    logic [4:0]  rot;
    x     = (old >> 18) ^ old;
    mixed = x[58:27];
    rot   = old[63:59];
    permute = (mixed >> rot) | (mixed << ((6'd32 - {1'b0, rot}) & 6'd31));
  endfunction
endpackage

FILE: hdl/pcgr_front.sv
// Front part: accepts items, classifies them and queues commands.
`timescale 1ns / 1ps
module pcgr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      action,
  input  logic [30:0]     bound,
  output logic            cmd_valid,
  input  logic            cmd_take,
  output pcgr_pkg::cmd_t  cmd
);
  pcgr_pkg::cmd_t q [2];
  logic           wp, rp;
  logic [1:0]     cnt;
  logic           push, pop;

  assign in_stall  = (cnt == 2'd2);
  assign push      = in_valid && !in_stall && (action != pcgr_pkg::ACT_NONE);
  assign cmd_valid = (cnt != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp].op    <= pcgr_pkg::action_t'(action);
      q[wp].zero  <= (bound == 31'd0);
      q[wp].bound <= bound;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: hdl/pcgr_back.sv
// Back part: generator state, remainder unit, draws and result register.
`timescale 1ns / 1ps
module pcgr_back #(
  parameter int FRACTION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [63:0]              seed,
  input  logic                     cmd_valid,
  output logic                     cmd_take,
  input  pcgr_pkg::cmd_t           cmd,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [31:0]              value,
  output logic [FRACTION_BITS-1:0] fraction,
  output logic                     bad_bound
);
  typedef enum logic [3:0] {
    S_INIT0, S_INIT1, S_IDLE, S_REM, S_DRAW, S_MLO, S_MHI, S_CHECK, S_RAW,
    S_SEED_A, S_SEED_B, S_SEED_C
  } state_t;

  state_t      st;
  logic [63:0] gs;
  logic [63:0] p0, p1;
  logic [31:0] rem, rdv, draw;
  logic [30:0] bnd;
  logic [5:0]  rcnt;
  logic [32:0] rtry;
  logic [63:0] prod;
  logic        busy;

  assign busy     = out_valid && out_stall;
  assign cmd_take = (st == S_IDLE) && !busy;
  assign rtry     = {rem, rdv[31]} - {2'b0, bnd};

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_INIT0;
      gs        <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (st)
        S_INIT0, S_SEED_A: begin
          p0 <= pcgr_pkg::LCG_INC;
          st <= (st == S_INIT0) ? S_INIT1 : S_SEED_B;
        end
        S_INIT1, S_SEED_B: begin
          gs <= p0 + seed;
          st <= S_SEED_C;
        end
        S_SEED_C: begin
          p0 <= gs[31:0] * pcgr_pkg::LCG_MUL[31:0];
          p1 <= {gs[31:0] * pcgr_pkg::LCG_MUL[63:32], 32'd0}
              + {gs[63:32] * pcgr_pkg::LCG_MUL[31:0], 32'd0};
          st <= S_RAW;
          bnd <= 31'd0;
        end
        S_IDLE: if (cmd_valid && !busy) begin
          bnd <= cmd.bound;
          unique case (cmd.op)
            pcgr_pkg::ACT_RAW: begin
              // raw draws ignore the bound field
              bnd  <= 31'd0;
              draw <= pcgr_pkg::permute(gs);
              st   <= S_DRAW;
            end
            pcgr_pkg::ACT_BOUND: begin
              if (cmd.zero) begin
                value     <= 32'd0;
                fraction  <= '0;
                bad_bound <= 1'b1;
                out_valid <= 1'b1;
              end else begin
                // (2^32 - b) mod b, restoring, one bit a cycle
                rdv  <= 32'd0 - {1'b0, cmd.bound};
                rem  <= 32'd0;
                rcnt <= 6'd32;
                st   <= S_REM;
              end
            end
            pcgr_pkg::ACT_RESEED: st <= S_SEED_A;
            default: ;
          endcase
        end
        S_REM: begin
          rem  <= rtry[32] ? {rem[30:0], rdv[31]} : rtry[31:0];
          rdv  <= {rdv[30:0], 1'b0};
          rcnt <= rcnt - 6'd1;
          if (rcnt == 6'd1) begin
            draw <= pcgr_pkg::permute(gs);
            st   <= S_DRAW;
          end
        end
        S_DRAW: begin
          // state advance, split into 32x32 products
          p0   <= gs[31:0] * pcgr_pkg::LCG_MUL[31:0];
          p1   <= {gs[31:0] * pcgr_pkg::LCG_MUL[63:32], 32'd0}
                + {gs[63:32] * pcgr_pkg::LCG_MUL[31:0], 32'd0};
          prod <= draw * {1'b0, bnd};
          st   <= S_MLO;
        end
        S_MLO: begin
          gs <= p0 + p1 + pcgr_pkg::LCG_INC;
          st <= (bnd == 31'd0) ? S_CHECK : S_MHI;
        end
        S_MHI: begin
          if (prod[31:0] < rem) begin
            draw <= pcgr_pkg::permute(gs);
            st   <= S_DRAW;
          end else if (!busy) begin
            value     <= prod[63:32];
            fraction  <= '0;
            bad_bound <= 1'b0;
            out_valid <= 1'b1;
            st        <= S_IDLE;
          end
        end
        S_CHECK: if (!busy) begin
          value     <= draw;
          fraction  <= draw[31 -: FRACTION_BITS];
          bad_bound <= 1'b0;
          out_valid <= 1'b1;
          st        <= S_IDLE;
        end
        S_RAW: begin
          gs <= p0 + p1 + pcgr_pkg::LCG_INC;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/pcg32_bounded_random_generator_core.sv
// Top level of the PCG32 bounded random generator.
//   channel | direction | handshake
//   in      | input     | in_valid / in_stall, action, bound
//   out     | output    | out_valid / out_stall, value, fraction, bad_bound
//   cfg     | input     | cfg_valid / cfg_ready, cfg_data (seed)
// A raw draw runs from its command through the draw, multiply and check
// states to the result; a bounded draw first runs the bit-serial remainder
// unit, and each rejection repeats the draw. After reset and on reseed the
// state is seeded through the seeding states before the next command is taken.
// A two-entry command queue lets the front accept while the back works.
`timescale 1ns / 1ps
module pcg32_bounded_random_generator_core #(
  parameter int FRACTION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  logic [30:0]              bound,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [31:0]              value,
  output logic [FRACTION_BITS-1:0] fraction,
  output logic                     bad_bound,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [63:0]              cfg_data
);
  logic           cmd_valid, cmd_take;
  pcgr_pkg::cmd_t cmd;
  logic [63:0]    seed;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) seed <= 64'd0;
    else if (cfg_valid && cfg_ready) seed <= cfg_data;
  end

  pcgr_front u_front (
    .clk, .rst, .in_valid, .in_stall, .action, .bound,
    .cmd_valid, .cmd_take, .cmd
  );

  pcgr_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst, .seed, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .value, .fraction, .bad_bound
  );

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_bound |-> value == 32'd0)
    else $error("bad bound result carries a value");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value))
    else $error("stalled result lost");
  a_take: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !(out_valid && out_stall))
    else $error("command taken while output blocked");
endmodule
